@@ sv/i2cm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// phase codes, register indexes and shared beat types of the i2c master
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_SDA1 = 5'd1;
    localparam logic [4:0] PH_ST_SCL1 = 5'd2;
    localparam logic [4:0] PH_ST_SDA0 = 5'd3;
    localparam logic [4:0] PH_ST_SCL0 = 5'd4;
    localparam logic [4:0] PH_SB_SET  = 5'd5;
    localparam logic [4:0] PH_SB_HIGH = 5'd6;
    localparam logic [4:0] PH_SB_LOW  = 5'd7;
    localparam logic [4:0] PH_AK_REL  = 5'd8;
    localparam logic [4:0] PH_AK_HIGH = 5'd9;
    localparam logic [4:0] PH_AK_POLL = 5'd10;
    localparam logic [4:0] PH_AK_LOW  = 5'd11;
    localparam logic [4:0] PH_RB_HIGH = 5'd12;
    localparam logic [4:0] PH_RB_LOW  = 5'd13;
    localparam logic [4:0] PH_MA_SDA  = 5'd14;
    localparam logic [4:0] PH_MA_HIGH = 5'd15;
    localparam logic [4:0] PH_MA_LOW  = 5'd16;
    localparam logic [4:0] PH_MA_REL  = 5'd17;
    localparam logic [4:0] PH_SP_SDA0 = 5'd18;
    localparam logic [4:0] PH_SP_SCL1 = 5'd19;
    localparam logic [4:0] PH_SP_SDA1 = 5'd20;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] REG_HALF_PERIOD = 8'd0;
    localparam logic [7:0] REG_ACK_TIMEOUT = 8'd1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd51;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] ack_timeout_polls;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] read_length;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       data_valid;
        logic [7:0] read_data;
        logic       last_byte;
        logic       done_res;
        logic       success;
    } res_t;

endpackage
`default_nettype wire

@@ sv/i2c_master_register_access.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_access
// i2c master for register writes and burst register reads, one tick per beat
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one beat per bus timer tick, carrying the command fields and
//     the sampled sda level; a write or read command is taken only when idle
//   m_ channel: one result beat per input beat with the scl/sda levels to
//     drive, busy, received bytes and the done/success flags
//   cfg_ channel: register writes (0 half period ticks, 1 ack timeout polls),
//     always ready; the user must issue them while the block is idle (unchecked)
// timing:
//   one input beat per clock while s_ready is high; the sequencer advances in the
//   cycle of the accept and its result goes to the output register or the skid
// reset:
//   aresetn low puts the sequencer in idle with both lines released and
//   loads the default register values
// stall:
//   a two-entry output stage (output register plus skid) keeps s_ready high
//   while one result waits; s_ready drops only when both entries are full
// ----------------------------------------------------------------------------
module i2c_master_register_access
    import i2cm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // tick / command channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_operation,
    input  wire logic [7:0] s_device_address,
    input  wire logic [7:0] s_register_address,
    input  wire logic [7:0] s_write_value,
    input  wire logic [7:0] s_read_length,
    input  wire logic       s_sda_in,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_scl_out,
    output logic            m_sda_out,
    output logic            m_busy_res,
    output logic            m_data_valid,
    output logic [7:0]      m_read_data,
    output logic            m_last_byte,
    output logic            m_done_res,
    output logic            m_success,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    res_t res;

    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic s_accept;

    assign cfg_ready = 1'b1;

    i2cm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cmd.operation        = s_operation;
    assign cmd.device_address   = s_device_address;
    assign cmd.register_address = s_register_address;
    assign cmd.write_value      = s_write_value;
    assign cmd.read_length      = s_read_length;
    assign cmd.sda_in           = s_sda_in;

    // input beat taken as long as the skid entry is free
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    i2cm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (s_accept),
        .cmd     (cmd),
        .cfg     (cfg),
        .res     (res)
    );

    // output register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (s_accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_out    = out_reg.scl_out;
    assign m_sda_out    = out_reg.sda_out;
    assign m_busy_res   = out_reg.busy_res;
    assign m_data_valid = out_reg.data_valid;
    assign m_read_data  = out_reg.read_data;
    assign m_last_byte  = out_reg.last_byte;
    assign m_done_res   = out_reg.done_res;
    assign m_success    = out_reg.success;

endmodule
`default_nettype wire

@@ sv/i2cm_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_cfg
// configuration registers: bus delay step and acknowledge timeout
// ----------------------------------------------------------------------------
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       wr_en,
    input  wire logic [7:0] wr_index,
    input  wire logic [7:0] wr_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.ack_timeout_polls <= ACK_TIMEOUT_RESET;
        end else if (wr_en) begin
            // unknown indexes are dropped
            if (wr_index == REG_HALF_PERIOD) begin
                cfg_reg.half_period_ticks <= wr_data;
            end else if (wr_index == REG_ACK_TIMEOUT) begin
                cfg_reg.ack_timeout_polls <= wr_data;
            end
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ sv/i2cm_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_seq
// bus sequencer: advances the start/byte/ack/stop phases by one tick per beat
// ----------------------------------------------------------------------------
module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic tick_en,
    input  wire cmd_t cmd,
    input  wire cfg_t cfg,
    output res_t      res
);

    logic [4:0] phase_reg,   phase_next;
    logic [7:0] tick_reg,    tick_next;
    logic [7:0] poll_reg,    poll_next;
    logic [3:0] bit_reg,     bit_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] left_reg,    left_next;
    logic [7:0] dev_reg,     dev_next;
    logic [7:0] regad_reg,   regad_next;
    logic [7:0] value_reg,   value_next;
    logic       is_read_reg, is_read_next;
    logic       ack_ok_reg,  ack_ok_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;

    logic [7:0] hold_len;
    logic [7:0] tick_inc;
    logic       first;
    logic       hit;
    logic [7:0] shift_in;

    // zero delay acts as one tick
    assign hold_len = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        poll_next    = poll_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        dev_next     = dev_reg;
        regad_next   = regad_reg;
        value_next   = value_reg;
        is_read_next = is_read_reg;
        ack_ok_next  = ack_ok_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        res          = '0;

        // command launch, only when idle
        if (phase_reg == PH_IDLE && (cmd.operation inside {OP_WRITE, OP_READ})) begin
            dev_next     = cmd.device_address;
            regad_next   = cmd.register_address;
            is_read_next = (cmd.operation == OP_READ);
            value_next   = (cmd.operation == OP_READ) ? cmd.read_length : cmd.write_value;
            ack_ok_next  = 1'b1;
            left_next    = 8'd0;
            bit_next     = 4'd0;
            poll_next    = 8'd0;
            tick_next    = 8'd0;
            phase_next   = PH_ST_SDA1;
        end

        first    = (tick_next == 8'd0);
        tick_inc = tick_next + 8'd1;
        hit      = (tick_inc >= hold_len);
        shift_in = {shift_next[6:0], cmd.sda_in};

        if (phase_next != PH_IDLE) begin
            case (phase_next)
                PH_ST_SDA1: begin
                    if (first) sda_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_ST_SCL1;
                end
                PH_ST_SCL1: begin
                    if (first) scl_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_ST_SDA0;
                end
                PH_ST_SDA0: begin
                    if (first) sda_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_ST_SCL0;
                end
                PH_ST_SCL0: begin
                    if (first) scl_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) begin
                        // repeated start sends device byte plus one
                        shift_next = (left_next == 8'd0) ? dev_next : dev_next + 8'd1;
                        bit_next   = 4'd0;
                        phase_next = PH_SB_SET;
                    end
                end
                PH_SB_SET: begin
                    if (first) sda_next = shift_next[7];
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_SB_HIGH;
                end
                PH_SB_HIGH: begin
                    if (first) scl_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_SB_LOW;
                end
                PH_SB_LOW: begin
                    // single-tick scl fall after a sent bit
                    scl_next   = 1'b0;
                    tick_next  = 8'd0;
                    bit_next   = bit_next + 4'd1;
                    shift_next = {shift_next[6:0], 1'b0};
                    phase_next = (bit_next < 4'd8) ? PH_SB_SET : PH_AK_REL;
                end
                PH_AK_REL: begin
                    if (first) sda_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_AK_HIGH;
                end
                PH_AK_HIGH: begin
                    if (first) begin
                        scl_next  = 1'b1;
                        poll_next = 8'd0;
                    end
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_AK_POLL;
                end
                PH_AK_POLL: begin
                    tick_next = 8'd0;
                    if (!cmd.sda_in) begin
                        phase_next = PH_AK_LOW;
                    end else if (poll_next >= cfg.ack_timeout_polls) begin
                        ack_ok_next = 1'b0;
                        phase_next  = PH_AK_LOW;
                    end else begin
                        poll_next = poll_next + 8'd1;
                    end
                end
                PH_AK_LOW: begin
                    if (first) scl_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) begin
                        if (left_next == 8'd0) begin
                            left_next  = 8'd1;
                            shift_next = regad_next;
                            bit_next   = 4'd0;
                            phase_next = PH_SB_SET;
                        end else if (left_next == 8'd1) begin
                            left_next = 8'd2;
                            if (is_read_next) begin
                                phase_next = PH_ST_SDA1;
                            end else begin
                                shift_next = value_next;
                                bit_next   = 4'd0;
                                phase_next = PH_SB_SET;
                            end
                        end else if (is_read_next) begin
                            left_next  = (value_next == 8'd0) ? 8'd1 : value_next;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RB_HIGH;
                        end else begin
                            phase_next = PH_SP_SDA0;
                        end
                    end
                end
                PH_RB_HIGH: begin
                    if (first) scl_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) begin
                        shift_next = shift_in;
                        bit_next   = bit_next + 4'd1;
                        if (bit_next >= 4'd8) begin
                            res.data_valid = 1'b1;
                            res.read_data  = shift_in;
                            res.last_byte  = (left_next <= 8'd1);
                        end
                        phase_next = PH_RB_LOW;
                    end
                end
                PH_RB_LOW: begin
                    if (first) scl_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = (bit_next >= 4'd8) ? PH_MA_SDA : PH_RB_HIGH;
                end
                PH_MA_SDA: begin
                    // ack all but the last byte
                    if (first) sda_next = (left_next > 8'd1) ? 1'b0 : 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_MA_HIGH;
                end
                PH_MA_HIGH: begin
                    if (first) scl_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_MA_LOW;
                end
                PH_MA_LOW: begin
                    if (first) scl_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = (left_next > 8'd1) ? PH_MA_REL : PH_SP_SDA0;
                end
                PH_MA_REL: begin
                    if (first) sda_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) begin
                        left_next  = left_next - 8'd1;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        phase_next = PH_RB_HIGH;
                    end
                end
                PH_SP_SDA0: begin
                    if (first) sda_next = 1'b0;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_SP_SCL1;
                end
                PH_SP_SCL1: begin
                    if (first) scl_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) phase_next = PH_SP_SDA1;
                end
                PH_SP_SDA1: begin
                    if (first) sda_next = 1'b1;
                    tick_next = hit ? 8'd0 : tick_inc;
                    if (hit) begin
                        res.done_res = 1'b1;
                        res.success  = ack_ok_next;
                        phase_next   = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    tick_next  = 8'd0;
                end
            endcase
        end

        res.scl_out  = scl_next;
        res.sda_out  = sda_next;
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 8'd0;
            poll_reg    <= 8'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            left_reg    <= 8'd0;
            dev_reg     <= 8'd0;
            regad_reg   <= 8'd0;
            value_reg   <= 8'd0;
            is_read_reg <= 1'b0;
            ack_ok_reg  <= 1'b1;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end else if (tick_en) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            poll_reg    <= poll_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            dev_reg     <= dev_next;
            regad_reg   <= regad_next;
            value_reg   <= value_next;
            is_read_reg <= is_read_next;
            ack_ok_reg  <= ack_ok_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

endmodule
`default_nettype wire
